// ----- rtl/ffpa_pkg.sv -----
// Package for the first-fit pool allocator: sizes, status, FSM, shift types.
// No dependencies.
`timescale 1ns / 1ps
package ffpa_pkg;
   localparam int PoolBytes = 4096;
   localparam int MaxBlocks = 64;
   localparam int AW = $clog2(PoolBytes);      // offset width
   localparam int LW = $clog2(PoolBytes) + 1;  // length width
   localparam int CW = $clog2(MaxBlocks) + 1;  // count width
   localparam int IW = $clog2(MaxBlocks);      // table index width

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_EXCEEDS   = 3'd1,
      ST_NO_GAP    = 3'd2,
      ST_FULL      = 3'd3,
      ST_NULL_FREE = 3'd4,
      ST_NOT_ALLOC = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_SHIFT, S_DONE
   } fsm_type;

   // shift command to the cell row
   typedef enum logic [1:0] {
      SH_HOLD, SH_ROTATE, SH_INSERT, SH_DELETE
   } shift_type;

   typedef struct packed {
      shift_type         op;
      logic [IW-1:0]     pos;
      logic [AW-1:0]     ins_start;
      logic [LW-1:0]     ins_len;
   } cell_ctl_type;
endpackage

// ----- rtl/ffpa_cell.sv -----
// One table cell: holds a (start, length) entry and passes it to its neighbor.
// Depends on ffpa_pkg.
`timescale 1ns / 1ps
module ffpa_cell
   import ffpa_pkg::*;
(
   input  logic          clock,
   input  cell_ctl_type  ctl,
   input  logic [IW-1:0] slot,      // fixed position of this cell in the row
   input  logic [AW-1:0] prev_start,
   input  logic [LW-1:0] prev_len,
   input  logic [AW-1:0] next_start,
   input  logic [LW-1:0] next_len,
   output logic [AW-1:0] start_ff,
   output logic [LW-1:0] len_ff
);
   logic [AW-1:0] start_in;
   logic [LW-1:0] len_in;

   always_comb begin
      start_in = start_ff;
      len_in   = len_ff;
      case (ctl.op)
         SH_ROTATE: begin
            start_in = next_start;
            len_in   = next_len;
         end
         SH_INSERT: begin
            if (slot == ctl.pos) begin
               start_in = ctl.ins_start;
               len_in   = ctl.ins_len;
            end else if (slot > ctl.pos) begin
               start_in = prev_start;
               len_in   = prev_len;
            end
         end
         SH_DELETE: begin
            if (slot >= ctl.pos) begin
               start_in = next_start;
               len_in   = next_len;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      len_ff   <= len_in;
   end
endmodule

// ----- rtl/first_fit_pool_allocator_core.sv -----
// Top level of the first-fit pool allocator: control FSM over a ring of cells.
// Depends on ffpa_pkg and ffpa_cell.
//
//  channel | direction | fields
//  req_    | in        | func, request_length, block_address, address_valid
//  rsp_    | out       | status, granted_start, remaining_bytes
//
// Cell k holds table entry k whenever the engine is idle. A scan rotates the
// ring one place a cycle for a full revolution of MaxBlocks (64) places, so
// cell 0 shows entry r and cell 1 entry r+1; the ring ends aligned again and
// the insert or delete step follows if a hit was found. One word in flight;
// req_ready is high only when idle, and a stalled response holds the engine.
// Synchronous reset; the cells are not reset, only entries below the count
// are read.
`timescale 1ns / 1ps
module first_fit_pool_allocator_core
   import ffpa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_func,
   input  logic [LW-1:0] req_request_length,
   input  logic [AW-1:0] req_block_address,
   input  logic          req_address_valid,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [2:0]    rsp_status,
   output logic [AW-1:0] rsp_granted_start,
   output logic [LW-1:0] rsp_remaining_bytes
);
   fsm_type       state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [LW-1:0] free_ff, free_in;
   logic [IW-1:0] rot_ff, rot_in;     // rotations done so far
   logic          found_ff, found_in;
   logic [IW-1:0] pos_ff, pos_in;     // table index of hit / insert place
   logic [AW-1:0] gstart_ff, gstart_in;
   logic [LW-1:0] dlen_ff, dlen_in;
   status_type    stat_ff, stat_in;
   logic          func_ff;
   logic [LW-1:0] len_ff;
   logic [AW-1:0] addr_ff;
   cell_ctl_type  ctl;

   logic [AW-1:0] c_start [MaxBlocks];
   logic [LW-1:0] c_len   [MaxBlocks];

   genvar g;
   generate
      for (g = 0; g < MaxBlocks; g++) begin : g_cell
         ffpa_cell u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .slot      (IW'(g)),
            .prev_start(c_start[(g + MaxBlocks - 1) % MaxBlocks]),
            .prev_len  (c_len[(g + MaxBlocks - 1) % MaxBlocks]),
            .next_start(c_start[(g + 1) % MaxBlocks]),
            .next_len  (c_len[(g + 1) % MaxBlocks]),
            .start_ff  (c_start[g]),
            .len_ff    (c_len[g])
         );
      end
   endgenerate

   // scan view: entry rot_ff sits in cell 0, its successor in cell 1
   logic [AW:0]   end_cur;
   logic [CW-1:0] idx;
   logic          is_last, in_tab;
   assign end_cur = {1'b0, c_start[0]} + c_len[0][AW:0];
   assign idx     = {1'b0, rot_ff};
   assign in_tab  = idx < count_ff;
   assign is_last = (idx + 1'b1) == count_ff;

   logic gap_ok, tail_ok;
   assign gap_ok  = !end_cur[AW] && end_cur[AW-1:0] <= c_start[1]
                  && len_ff <= {1'b0, c_start[1] - end_cur[AW-1:0]};
   assign tail_ok = end_cur < (AW+1)'(PoolBytes)
                  && len_ff <= (LW'(PoolBytes) - LW'(end_cur));

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      free_in   = free_ff;
      rot_in    = rot_ff;
      found_in  = found_ff;
      pos_in    = pos_ff;
      gstart_in = gstart_ff;
      dlen_in   = dlen_ff;
      stat_in   = stat_ff;
      case (state_ff)
         S_IDLE: begin
            rot_in   = '0;
            found_in = 1'b0;
            if (req_valid) begin
               gstart_in = '0;
               if (!req_func) begin
                  if (req_request_length > free_ff) begin
                     stat_in  = ST_EXCEEDS;
                     state_in = S_DONE;
                  end else if (count_ff >= CW'(MaxBlocks)) begin
                     stat_in  = ST_FULL;
                     state_in = S_DONE;
                  end else if (count_ff == '0) begin
                     found_in = 1'b1;
                     pos_in   = '0;
                     dlen_in  = req_request_length;
                     state_in = S_SHIFT;
                  end else begin
                     state_in = S_SCAN;
                  end
               end else if (!req_address_valid) begin
                  stat_in  = ST_NULL_FREE;
                  state_in = S_DONE;
               end else if (count_ff == '0) begin
                  stat_in  = ST_NOT_ALLOC;
                  state_in = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            rot_in = rot_ff + 1'b1;
            if (!found_ff && in_tab) begin
               if (!func_ff) begin
                  if ((!is_last && gap_ok) || (is_last && tail_ok)) begin
                     found_in  = 1'b1;
                     pos_in    = rot_ff + 1'b1;
                     gstart_in = end_cur[AW-1:0];
                  end
               end else if (c_start[0] == addr_ff) begin
                  found_in = 1'b1;
                  pos_in   = rot_ff;
                  dlen_in  = c_len[0];
               end
            end
            // last rotation of the revolution: ring is aligned next cycle
            if (rot_ff == IW'(MaxBlocks - 1)) begin
               if (found_in) begin
                  state_in = S_SHIFT;
               end else begin
                  stat_in  = func_ff ? ST_NOT_ALLOC : ST_NO_GAP;
                  state_in = S_DONE;
               end
            end
         end
         S_SHIFT: begin
            stat_in = ST_OK;
            if (!func_ff) begin
               count_in = count_ff + 1'b1;
               free_in  = free_ff - len_ff;
            end else begin
               count_in = count_ff - 1'b1;
               free_in  = free_ff + dlen_ff;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ctl.op        = SH_HOLD;
      ctl.pos       = pos_ff;
      ctl.ins_start = gstart_ff;
      ctl.ins_len   = len_ff;
      if (state_ff == S_SCAN) ctl.op = SH_ROTATE;
      else if (state_ff == S_SHIFT) ctl.op = func_ff ? SH_DELETE : SH_INSERT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         free_ff  <= LW'(PoolBytes);
         rot_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         free_ff  <= free_in;
         rot_ff   <= rot_in;
         found_ff <= found_in;
      end
      pos_ff    <= pos_in;
      gstart_ff <= gstart_in;
      dlen_ff   <= dlen_in;
      stat_ff   <= stat_in;
      if (req_valid && req_ready) begin
         func_ff <= req_func;
         len_ff  <= req_request_length;
         addr_ff <= req_block_address;
      end
   end

   assign req_ready           = state_ff == S_IDLE;
   assign rsp_valid           = state_ff == S_DONE;
   assign rsp_status          = stat_ff;
   assign rsp_granted_start   = stat_ff == ST_OK ? gstart_ff : '0;
   assign rsp_remaining_bytes = free_ff;

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= LW'(PoolBytes)) else $error("free bytes above pool");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MaxBlocks)) else $error("count above table size");
   a_shift_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SHIFT |=> state_ff == S_DONE) else $error("shift not one cycle");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response word dropped");
endmodule

// ----- tb/tb_top.sv -----
// Testbench for first_fit_pool_allocator_core: drives allocate/free words and
// checks every response against a built-in first-fit table model.
// Depends on ffpa_pkg and the allocator RTL.
`timescale 1ns / 1ps
module tb_top
   import ffpa_pkg::*;
();

   typedef struct packed {
      status_type    status;
      logic [AW-1:0] granted;
      logic [LW-1:0] remaining;
   } alloc_result_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic          req_func = 1'b0;
   logic [LW-1:0] req_request_length = '0;
   logic [AW-1:0] req_block_address = '0;
   logic          req_address_valid = 1'b0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic [2:0]    rsp_status;
   logic [AW-1:0] rsp_granted_start;
   logic [LW-1:0] rsp_remaining_bytes;

   first_fit_pool_allocator_core uut (.*);

   always #5 clock = ~clock;

   // model state
   int unsigned      blk_start[MaxBlocks];
   int unsigned      blk_len[MaxBlocks];
   int unsigned      blk_count = 0;
   int unsigned      pool_free = PoolBytes;
   alloc_result_type pending_q[$];
   int               errors = 0;
   int               hold_reqs = 0;   // bumped by a test to start a long stall
   int               hold_seen = 0;
   int               hold_left = 0;
   int               busy_mode = 0;   // 0 random bursts, 1 no gaps

   function automatic void table_insert(int unsigned pos, int unsigned st,
                                        int unsigned ln);
      for (int unsigned k = blk_count; k > pos; k--) begin
         blk_start[k] = blk_start[k-1];
         blk_len[k] = blk_len[k-1];
      end
      blk_start[pos] = st;
      blk_len[pos] = ln;
      blk_count++;
      pool_free -= ln;
   endfunction

   function automatic alloc_result_type predict_alloc(logic fn, int unsigned ln,
                                                      int unsigned addr, logic av);
      alloc_result_type r;
      int unsigned      e;
      bit               done;
      r.status = ST_OK;
      r.granted = '0;
      done = 0;
      if (!fn) begin
         if (ln > pool_free) r.status = ST_EXCEEDS;
         else if (blk_count >= MaxBlocks) r.status = ST_FULL;
         else if (blk_count == 0) table_insert(0, 0, ln);
         else begin
            for (int unsigned i = 0; i + 1 < blk_count && !done; i++) begin
               e = blk_start[i] + blk_len[i];
               if (e <= blk_start[i+1] && ln <= blk_start[i+1] - e) begin
                  table_insert(i + 1, e, ln);
                  r.granted = AW'(e);
                  done = 1;
               end
            end
            if (!done) begin
               e = blk_start[blk_count-1] + blk_len[blk_count-1];
               if (e < PoolBytes && ln <= PoolBytes - e) begin
                  table_insert(blk_count, e, ln);
                  r.granted = AW'(e);
               end else r.status = ST_NO_GAP;
            end
         end
      end else if (!av) r.status = ST_NULL_FREE;
      else begin
         r.status = ST_NOT_ALLOC;
         for (int unsigned i = 0; i < blk_count && !done; i++) begin
            if (blk_start[i] == addr) begin
               pool_free += blk_len[i];
               for (int unsigned k = i; k + 1 < blk_count; k++) begin
                  blk_start[k] = blk_start[k+1];
                  blk_len[k] = blk_len[k+1];
               end
               blk_count--;
               r.status = ST_OK;
               done = 1;
            end
         end
      end
      r.remaining = LW'(pool_free);
      return r;
   endfunction

   // send one word, with a random gap in burst mode
   task automatic send_word(logic fn, int unsigned ln, int unsigned addr, logic av);
      if (busy_mode == 0 && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= fn;
      req_request_length <= ln[LW-1:0];
      req_block_address <= addr[AW-1:0];
      req_address_valid <= av;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_q.push_back(predict_alloc(fn, ln, addr, av));
   endtask

   task automatic do_alloc(int unsigned ln);
      send_word(1'b0, ln, $urandom_range(0, 4095), 1'($urandom_range(0, 1)));
   endtask

   task automatic do_free(int unsigned addr);
      send_word(1'b1, $urandom_range(0, 8191), addr, 1'b1);
   endtask

   // pick a live block start most of the time
   function automatic int unsigned pick_addr();
      if (blk_count != 0 && $urandom_range(0, 4) != 0)
         return blk_start[$urandom_range(0, blk_count - 1)];
      return $urandom_range(0, 4095);
   endfunction

   // receiver stall pattern, with a long hold-off on request
   always @(posedge clock) begin
      if (hold_seen != hold_reqs) begin
         hold_seen <= hold_reqs;
         hold_left <= 400;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else rsp_ready <= ($urandom_range(0, 9) < 7);
   end

   always @(posedge clock) begin
      alloc_result_type x;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected word status=%0d", $time, rsp_status);
            errors++;
         end else begin
            x = pending_q.pop_front();
            if (rsp_status !== x.status) begin
               $display("%0t: status exp %0d got %0d", $time, x.status, rsp_status);
               errors++;
            end
            if (rsp_granted_start !== x.granted) begin
               $display("%0t: granted_start exp %0d got %0d", $time, x.granted,
                        rsp_granted_start);
               errors++;
            end
            if (rsp_remaining_bytes !== x.remaining) begin
               $display("%0t: remaining_bytes exp %0d got %0d", $time, x.remaining,
                        rsp_remaining_bytes);
               errors++;
            end
         end
      end
   end

   task automatic test_directed();
      do_free(0);                          // free on empty table
      send_word(1'b1, 0, 0, 1'b0);         // null handle
      do_alloc(4097);                      // exceeds pool
      do_alloc(8191);
      do_alloc(0);                         // zero length at 0
      do_alloc(100);                       // shares offset 0
      do_alloc(4096 - 100);                // fills the pool exactly
      do_alloc(0);                         // zero length, fits at offset 0
      do_free(0);                          // first block at 0
      do_free(100);
      do_alloc(50);
      do_free(0);
      do_free(4095);
      do_free(100);
      do_alloc(4096);
      do_free(0);
      send_word(1'b1, 8191, 4095, 1'b0);
   endtask

   task automatic test_table_full();
      for (int i = 0; i < MaxBlocks + 2; i++) do_alloc($urandom_range(0, 3));
      // open interior gaps then refill
      for (int i = 0; i < 8; i++) do_free(blk_start[$urandom_range(1, blk_count - 2)]);
      for (int i = 0; i < 10; i++) do_alloc($urandom_range(0, 6));
      while (blk_count > 0) do_free(blk_start[0]);
   endtask

   task automatic test_backpressure();
      busy_mode = 1;
      hold_reqs++;
      for (int i = 0; i < 12; i++) do_alloc($urandom_range(1, 200));
      busy_mode = 0;
   endtask

   task automatic test_random(int n);
      int unsigned k;
      for (int i = 0; i < n; i++) begin
         if (i % 200 == 0) busy_mode = $urandom_range(0, 1);
         k = $urandom_range(0, 99);
         if (k < 45) begin
            if ($urandom_range(0, 9) == 0) do_alloc($urandom_range(0, 8191));
            else if ($urandom_range(0, 3) == 0) do_alloc($urandom_range(0, 4));
            else do_alloc($urandom_range(1, 300));
         end else if (k < 90) do_free(pick_addr());
         else send_word(1'($urandom_range(0, 1)), $urandom_range(0, 8191),
                        $urandom_range(0, 4095), 1'($urandom_range(0, 1)));
      end
      busy_mode = 0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_table_full();
      test_backpressure();
      test_random(1500);
      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (MaxBlocks + 10) @(posedge clock);
      if (errors == 0) $display("tb_top: PASS");
      else $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      #20ms;
      $display("tb_top: FAIL");
      $finish;
   end
endmodule

// ----- filelist.f -----
rtl/ffpa_pkg.sv
rtl/ffpa_cell.sv
rtl/first_fit_pool_allocator_core.sv
tb/tb_top.sv
